// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame CRC checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FCC_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fcc_pkg.sv
// ----------------------------------------------------------------------------
// Frame CRC checker package
// Types, constants and the byte-wide CRC-16 update shared by the modules.
// ----------------------------------------------------------------------------
package fcc_pkg;

    typedef logic [16:0] idx_t;

    localparam idx_t        HDR_BYTES  = 17'd8;
    localparam idx_t        HDR_LEN_LO = 17'd6;
    localparam idx_t        HDR_LEN_HI = 17'd7;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_TOP    = 16'h8000;
    localparam logic [15:0] LIMIT_RST  = 16'd255;
    localparam logic [7:0]  MAGIC_RST  = 8'd0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    typedef enum logic [1:0] {
        ST_VALID,
        ST_BAD_MAGIC,
        ST_LEN_OVER,
        ST_CRC_MISMATCH
    } status_t;

    typedef enum logic {
        REG_SYNC_MAGIC,
        REG_PAYLOAD_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  sync_magic;
        logic [15:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] declared_length;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = (c << 1) ^ CRC_POLY;
            else
                c = c << 1;
        end
        return c;
    endfunction

endpackage

// File: design/fcc_in_if.sv
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one received frame byte per item.
// ----------------------------------------------------------------------------
interface fcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// File: design/fcc_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one frame check result per item.
// ----------------------------------------------------------------------------
interface fcc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] declared_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    modport source (output valid, output status, output declared_length,
                    output computed_crc, output received_crc, input ready);
    modport sink   (input valid, input status, input declared_length,
                    input computed_crc, input received_crc, output ready);
endinterface

// File: design/fcc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fcc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/fcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the expected sync magic and the payload length limit.
// ----------------------------------------------------------------------------
module fcc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    fcc_cfg_if.sink       cfg,
    output fcc_pkg::cfg_t cfg_q
);
    import fcc_pkg::*;

    logic [7:0]  magic_reg;
    logic [7:0]  magic_next;
    logic [15:0] limit_reg;
    logic [15:0] limit_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        magic_next = magic_reg;
        limit_next = limit_reg;
        if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_SYNC_MAGIC:    magic_next = cfg.data[7:0];
                REG_PAYLOAD_LIMIT: limit_next = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= MAGIC_RST;
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            magic_reg <= magic_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg_q.sync_magic    = magic_reg;
    assign cfg_q.payload_limit = limit_reg;

endmodule

// File: design/fcc_frame_core.sv
// ----------------------------------------------------------------------------
// Frame checker core
// Input register, frame parser state and byte-wide CRC update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcc_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    fcc_in_if.sink           rx,
    input  fcc_pkg::cfg_t    cfg_q,
    input  logic             out_room,
    output logic             res_valid,
    output fcc_pkg::result_t res_data
);
    import fcc_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_start_reg;
    logic        s1_adv;

    phase_t      phase_reg,  phase_next;
    idx_t        idx_reg,    idx_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] len_reg,    len_next;
    logic [7:0]  tlow_reg,   tlow_next;

    phase_t      ph_e;
    idx_t        idx_e;
    logic [15:0] crc_e;
    logic [15:0] len_e;
    logic [7:0]  tlow_e;
    idx_t        idx_inc;
    idx_t        frame_end;
    idx_t        frame_end_reg;
    logic [15:0] rcrc;
    logic        emit;

    // input register
    assign s1_adv   = s1_valid_reg && (out_room || !emit);
    assign rx.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (rx.ready)
            s1_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_byte_reg  <= 8'h00;
            s1_start_reg <= 1'b0;
        end
        else if (rx.ready && rx.valid)
        begin
            s1_byte_reg  <= rx.rx_byte;
            s1_start_reg <= rx.frame_start;
        end
    end

    // frame start restarts the parser
    always_comb
    begin
        ph_e   = s1_start_reg ? PH_HEADER : phase_reg;
        idx_e  = s1_start_reg ? '0        : idx_reg;
        crc_e  = s1_start_reg ? CRC_INIT  : crc_reg;
        len_e  = s1_start_reg ? 16'h0000  : len_reg;
        tlow_e = s1_start_reg ? 8'h00     : tlow_reg;
    end

    assign idx_inc       = idx_e + 17'd1;
    assign frame_end     = HDR_BYTES + {1'b0, len_e};
    assign frame_end_reg = HDR_BYTES + {1'b0, len_reg};
    assign rcrc          = {s1_byte_reg, tlow_e};

    always_comb
    begin
        phase_next = ph_e;
        idx_next   = idx_e;
        crc_next   = crc_e;
        len_next   = len_e;
        tlow_next  = tlow_e;
        emit       = 1'b0;
        res_data   = '{status: ST_VALID, declared_length: 16'h0000,
                       computed_crc: crc_e, received_crc: 16'h0000};
        unique case (ph_e)
            PH_IDLE:
            begin
            end
            PH_HEADER:
            begin
                crc_next              = crc_byte(crc_e, s1_byte_reg);
                res_data.computed_crc = crc_next;
                if (idx_e == '0 && s1_byte_reg != cfg_q.sync_magic)
                begin
                    emit            = 1'b1;
                    res_data.status = ST_BAD_MAGIC;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    if (idx_e == HDR_LEN_LO)
                        len_next = {8'h00, s1_byte_reg};
                    else if (idx_e == HDR_LEN_HI)
                        len_next = {s1_byte_reg, len_e[7:0]};
                    idx_next = idx_inc;
                    if (idx_inc == HDR_BYTES)
                    begin
                        if (len_next > cfg_q.payload_limit)
                        begin
                            emit                     = 1'b1;
                            res_data.status          = ST_LEN_OVER;
                            res_data.declared_length = len_next;
                            phase_next               = PH_IDLE;
                        end
                        else if (len_next == 16'h0000)
                            phase_next = PH_TRAILER;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_byte(crc_e, s1_byte_reg);
                idx_next = idx_inc;
                if (idx_inc == frame_end)
                    phase_next = PH_TRAILER;
            end
            PH_TRAILER:
            begin
                idx_next = idx_inc;
                if (idx_e == frame_end)
                    tlow_next = s1_byte_reg;
                else
                begin
                    emit                     = 1'b1;
                    res_data.status          = (rcrc == crc_e) ? ST_VALID : ST_CRC_MISMATCH;
                    res_data.declared_length = len_e;
                    res_data.received_crc    = rcrc;
                    phase_next               = PH_IDLE;
                end
            end
        endcase
    end

    assign res_valid = s1_adv && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            crc_reg   <= CRC_INIT;
            len_reg   <= 16'h0000;
            tlow_reg  <= 8'h00;
        end
        else if (s1_adv)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            tlow_reg  <= tlow_next;
        end
    end

    `FCC_ASSERT(core_idle_silent, (s1_valid_reg && phase_reg == PH_IDLE && !s1_start_reg) |-> !emit, "byte outside a frame produced a result")
    `FCC_ASSERT(core_emit_ends_frame, res_valid |=> (phase_reg == PH_IDLE), "frame not closed after its result")
    `FCC_ASSERT(core_payload_range, (phase_reg == PH_PAYLOAD) |-> (idx_reg >= HDR_BYTES && idx_reg < frame_end_reg), "byte index outside payload")

endmodule

// File: design/fcc_out_stage.sv
// ----------------------------------------------------------------------------
// Result output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fcc_pkg::result_t load_data,
    output logic             room,
    fcc_out_if.source        result
);
    import fcc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign room = !valid_reg || result.ready;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign result.valid           = valid_reg;
    assign result.status          = data_reg.status;
    assign result.declared_length = data_reg.declared_length;
    assign result.computed_crc    = data_reg.computed_crc;
    assign result.received_crc    = data_reg.received_crc;

    `FCC_ASSERT(out_no_overwrite, load |-> room, "result loaded over an untaken result")
    `FCC_ASSERT_NR(out_reset_empty, !rst_n |=> !valid_reg, "result valid during reset")

endmodule

// File: design/frame_crc_checker.sv
// ----------------------------------------------------------------------------
// Frame CRC checker
// Byte-serial receive frame checker with CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Usage:
//   rx     : one frame byte per item, frame_start marks header byte 0.
//   result : one item per frame: status, declared length, computed and
//            received CRC. Bad magic and over-limit length end a frame early.
//   cfg    : index 0 writes sync_magic (data[7:0]), index 1 payload_limit.
//            Always ready; write only while no frame result is pending.
// Timing:
//   A byte goes through the input register, then the parser and CRC update
//   into the result register, which takes the result item of the byte that
//   ends a frame once it has room. One byte per cycle sustained, except while a
//   result waits for that room; the byte-wide CRC update sets that rate.
// Reset:
//   Parser idle, CRC at 0xFFFF, sync_magic 0, payload_limit 255, both
//   channels empty. No memory clearing pass.
// Stall:
//   A waiting result holds; bytes that give no result keep flowing, and the
//   input register holds a result-producing byte until the result register
//   frees up.
// ----------------------------------------------------------------------------
module frame_crc_checker (
    input  logic      clk,
    input  logic      rst_n,
    fcc_in_if.sink    rx,
    fcc_out_if.source result,
    fcc_cfg_if.sink   cfg
);
    import fcc_pkg::*;

    cfg_t    cfg_q;
    logic    out_room;
    logic    res_valid;
    result_t res_data;

    fcc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    fcc_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg_q     (cfg_q),
        .out_room  (out_room),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    fcc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res_data),
        .room      (out_room),
        .result    (result)
    );

endmodule

// File: dv/tb_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// Frame CRC checker testbench
// Feeds byte streams with well-formed, corrupted, truncated and over-limit
// frames plus stray bytes through the rx channel under random gaps and
// result back-pressure. A scoreboard tracks the parser and CRC state per byte
// and checks every frame verdict field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_frame_crc_checker;

    import fcc_pkg::*;

    localparam int FRAME_WHOLE = 32'h7FFF_FFFF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 300;

    class frame_verdict_board;
        result_t     pending_verdicts[$];
        int unsigned fault_count;
        logic [7:0]  magic_reg;
        logic [15:0] limit_reg;
        phase_t      parse_phase;
        idx_t        byte_pos;
        logic [15:0] crc_acc;
        logic [15:0] len_field;
        logic [7:0]  trail_lo;

        function new();
            fault_count = 0;
            magic_reg   = MAGIC_RST;
            limit_reg   = LIMIT_RST;
            parse_phase = PH_IDLE;
            byte_pos    = '0;
            crc_acc     = CRC_INIT;
            len_field   = '0;
            trail_lo    = '0;
        endfunction

        // bitwise CCITT update, data MSB first
        function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[15] ^ d[i];
                r  = {r[14:0], 1'b0};
                if (fb)
                    r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        function void set_register(cfg_reg_t which, logic [15:0] value);
            if (which == REG_SYNC_MAGIC)
                magic_reg = value[7:0];
            else
                limit_reg = value;
        endfunction

        function void close_frame(status_t st, logic [15:0] len, logic [15:0] rcrc);
            result_t r;
            r.status          = st;
            r.declared_length = len;
            r.computed_crc    = crc_acc;
            r.received_crc    = rcrc;
            pending_verdicts.push_back(r);
            parse_phase = PH_IDLE;
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            idx_t frame_end;
            if (start)
            begin
                parse_phase = PH_HEADER;
                byte_pos    = '0;
                crc_acc     = CRC_INIT;
                len_field   = '0;
                trail_lo    = '0;
            end
            frame_end = HDR_BYTES + idx_t'(len_field);
            case (parse_phase)
                PH_HEADER:
                begin
                    crc_acc = crc_next(crc_acc, b);
                    if (byte_pos == '0 && b != magic_reg)
                    begin
                        close_frame(ST_BAD_MAGIC, 16'h0000, 16'h0000);
                        return;
                    end
                    if (byte_pos == HDR_LEN_LO)
                        len_field = {8'h00, b};
                    else if (byte_pos == HDR_LEN_HI)
                        len_field[15:8] = b;
                    byte_pos = byte_pos + 17'd1;
                    if (byte_pos == HDR_BYTES)
                    begin
                        if (len_field > limit_reg)
                            close_frame(ST_LEN_OVER, len_field, 16'h0000);
                        else
                            parse_phase = (len_field == 16'h0000) ? PH_TRAILER : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_acc  = crc_next(crc_acc, b);
                    byte_pos = byte_pos + 17'd1;
                    if (byte_pos == frame_end)
                        parse_phase = PH_TRAILER;
                end
                PH_TRAILER:
                begin
                    if (byte_pos == frame_end)
                    begin
                        trail_lo = b;
                        byte_pos = byte_pos + 17'd1;
                    end
                    else
                    begin
                        byte_pos = byte_pos + 17'd1;
                        close_frame(({b, trail_lo} == crc_acc) ? ST_VALID : ST_CRC_MISMATCH,
                                    len_field, {b, trail_lo});
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                fault_count++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void match_verdict(logic [1:0] st, logic [15:0] len,
                                    logic [15:0] ccrc, logic [15:0] rcrc);
            result_t want;
            if (pending_verdicts.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected result, expected none, actual %0d %h %h %h",
                         $time, st, len, ccrc, rcrc);
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("status", 16'(want.status), 16'(st));
            compare_field("declared_length", want.declared_length, len);
            compare_field("computed_crc", want.computed_crc, ccrc);
            compare_field("received_crc", want.received_crc, rcrc);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    fcc_in_if  rx_ch ();
    fcc_out_if res_ch ();
    fcc_cfg_if cfg_ch ();

    frame_verdict_board board;
    bit          sender_gaps;
    bit          receiver_gaps;
    int          hold_request;
    int          phase_bytes;
    int unsigned cycle_count;

    frame_crc_checker u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= start;
        do @(posedge clk); while (!rx_ch.ready);
        board.take_byte(b, start);
        phase_bytes++;
    endtask

    // sends the first cut bytes of a frame; trailer optionally corrupted
    task automatic send_frame(input logic [7:0] first, input logic [15:0] plen,
                              input int cut, input bit spoil);
        logic [7:0]  hdr [8];
        logic [15:0] c;
        logic [15:0] trailer;
        logic [15:0] flip;
        logic [7:0]  b;
        int          total;
        foreach (hdr[i])
            hdr[i] = 8'($urandom);
        hdr[0] = first;
        hdr[6] = plen[7:0];
        hdr[7] = plen[15:8];
        total  = 10 + int'(plen);
        if (cut > total)
            cut = total;
        flip = spoil ? 16'($urandom_range(1, 65535)) : 16'h0000;
        c    = CRC_INIT;
        for (int n = 0; n < cut; n++)
        begin
            trailer = c ^ flip;
            if (n < 8)
                b = hdr[n];
            else if (n < 8 + int'(plen))
                b = 8'($urandom);
            else if (n == 8 + int'(plen))
                b = trailer[7:0];
            else
                b = trailer[15:8];
            if (n < 8 + int'(plen))
                c = board.crc_next(c, b);
            send_byte(b, n == 0);
        end
    endtask

    task automatic random_frame();
        int          kind;
        logic [15:0] cap;
        logic [15:0] plen;
        logic [7:0]  first;
        kind  = $urandom_range(0, 19);
        cap   = (board.limit_reg < 16) ? board.limit_reg : 16'd16;
        plen  = 16'($urandom_range(0, cap));
        first = board.magic_reg;
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
        else if (kind <= 2)
            send_frame(first ^ 8'($urandom_range(1, 255)), plen, $urandom_range(1, 12), 1'b0);
        else if (kind <= 4 && board.limit_reg != 16'hFFFF)
        begin
            if ($urandom_range(0, 1))
                plen = board.limit_reg + 16'd1;
            else
                plen = 16'($urandom_range(int'(board.limit_reg) + 1, 65535));
            send_frame(first, plen, 8 + $urandom_range(0, 3), 1'b0);
        end
        else if (kind <= 6)
            send_frame(first, plen, $urandom_range(1, 9 + int'(plen)), 1'b0);
        else if (kind == 7)
            send_frame(first, board.limit_reg,
                       (board.limit_reg <= 40) ? FRAME_WHOLE : $urandom_range(9, 40), 1'b0);
        else
            send_frame(first, plen, FRAME_WHOLE, kind <= 10);
    endtask

    task automatic drain_block();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (board.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t which, input logic [15:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= which;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_register(which, value);
    endtask

    task automatic run_phase(input logic [7:0] magic, input logic [15:0] limit,
                             input bit sg, input bit rg, input int hold, input bit big);
        drain_block();
        write_register(REG_SYNC_MAGIC, {8'($urandom), magic});
        write_register(REG_PAYLOAD_LIMIT, limit);
        @(negedge clk);
        cfg_ch.valid  <= 1'b0;
        sender_gaps   = sg;
        receiver_gaps = rg;
        hold_request  = hold;
        phase_bytes   = 0;
        if (big)
            send_frame(board.magic_reg, 16'd255, FRAME_WHOLE, 1'b0);
        while (phase_bytes < PHASE_BYTES)
            random_frame();
        send_frame(board.magic_reg, 16'd2, FRAME_WHOLE, 1'b0);
    endtask

    // result side: random ready gaps, plus long hold-offs on request
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (hold_request - 1) @(negedge clk);
                hold_request = 0;
            end
            gap = receiver_gaps ? $urandom_range(0, 13) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid && hold_request == 0);
            if (res_ch.valid)
                board.match_verdict(res_ch.status, res_ch.declared_length,
                                    res_ch.computed_crc, res_ch.received_crc);
        end
    end

    initial
    begin
        board             = new();
        sender_gaps       = 1'b1;
        receiver_gaps     = 1'b1;
        hold_request      = 0;
        phase_bytes       = 0;
        rst_n             = 1'b0;
        rx_ch.valid       = 1'b0;
        rx_ch.rx_byte     = 8'h00;
        rx_ch.frame_start = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_SYNC_MAGIC;
        cfg_ch.data       = 16'h0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: magic 0, limit 255
        send_byte(8'hFF, 1'b0);
        send_frame(8'h80, 16'd0, 1, 1'b0);
        send_frame(8'h00, 16'd0, FRAME_WHOLE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_frame(8'h00, 16'h0100, 8, 1'b0);
        send_frame(8'h00, 16'd3, 4, 1'b0);

        run_phase(8'hFF, 16'd0, 1'b1, 1'b1, 0, 1'b0);
        run_phase(8'h00, 16'hFFFF, 1'b0, 1'b0, 0, 1'b0);
        run_phase(8'hA5, 16'd12, 1'b1, 1'b0, 0, 1'b0);
        run_phase(8'($urandom), 16'd255, 1'b0, 1'b1, 0, 1'b1);
        run_phase(8'($urandom), 16'($urandom_range(0, 30)), 1'b0, 1'b1, 300, 1'b0);

        drain_block();
        repeat (10) @(posedge clk);
        if (board.fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
